/* rtl/core/rlr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlr_pkg
// Shared constants, types and state encoding for the rational linear resampler.
// ----------------------------------------------------------------------------
package rlr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int MAX_UP_FACTOR = 32;
  localparam int UP_W          = 6;
  localparam int DOWN_W        = 8;
  localparam int CFG_W         = 8;
  localparam int DIFF_W        = SAMPLE_BITS + 1;
  localparam int REM_W         = $clog2(MAX_UP_FACTOR);
  localparam int DIV_CNT_W     = $clog2(DIFF_W);

  localparam logic CFG_UP_FACTOR   = 1'b0;
  localparam logic CFG_DOWN_FACTOR = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [DIFF_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEG,
    ST_FLUSH
  } state_e;

endpackage

/* rtl/core/rlr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlr_div
// Bit-serial restoring divider: one quotient bit per cycle, segment slope
// magnitude divided by the up factor.
// ----------------------------------------------------------------------------
module rlr_div
  import rlr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIFF_W-1:0] dividend_i,
  input  logic [UP_W-1:0]   divisor_i,
  output logic              done_o,
  output div_res_t          res_o
);

  logic [DIFF_W-1:0]    shreg_q, shreg_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [UP_W-1:0]      rem_sh;
  logic [UP_W-1:0]      rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, shreg_q[DIFF_W-1]};
  assign ge      = (rem_sh >= divisor_i);
  assign rem_sub = rem_sh - divisor_i;

  always_comb begin
    shreg_d = shreg_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shreg_d = dividend_i;
      rem_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shreg_d = {shreg_q[DIFF_W-2:0], ge};
      rem_d   = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
  end

  assign done_o    = done_q;
  assign res_o.quot = shreg_q;
  assign res_o.rem  = rem_q;

endmodule

/* rtl/core/rational_linear_resampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_linear_resampler
// Linear-interpolation resampler by up_factor/down_factor for signed audio.
// ----------------------------------------------------------------------------
// Each input sample closes the segment from the previous sample and yields
// up_factor interpolated points, of which every down_factor-th is kept; a
// sample marked with tlast also emits its flat tail and clears the state.
// An input with a held predecessor passes through these steps in order: the
// transfer, the bit-serial divider that splits the segment slope into
// quotient and remainder, the incremental accumulator at one interpolated
// point per cycle unless output back-pressure holds it, up_factor more
// points for a tail, and the hand-over of the last result; only then is the
// next input taken. The first sample of a stream is held in its transfer
// cycle; a single-sample stream end skips the divider and emits only its
// flat tail. Output back-pressure stalls a kept point, or the hand-over of
// the last result, only when the staging and output registers are both full.
// tlast on the output marks the last result of an input, tuser the last
// result of the stream.
// ----------------------------------------------------------------------------
module rational_linear_resampler
  import rlr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [23:0] sample_in
  input  logic                   s_axis_tlast,   // end_of_stream
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // [23:0] sample_out
  output logic                   m_axis_tlast,   // run_last
  output logic                   m_axis_tuser    // [0] stream_done
);

  state_e state_q, state_d;

  logic [UP_W-1:0]   up_q;
  logic [DOWN_W-1:0] down_q;
  logic [UP_W-1:0]   up_eff;
  logic [DOWN_W-1:0] down_eff;

  sample_t           prev_q, cur_q, f0_q, pend_q, out_q;
  logic              have_q, last_q, tail_q, neg_q;
  logic              pend_v_q, out_v_q, out_last_q, out_user_q;
  logic [DOWN_W-1:0] phase_q;
  logic [DIFF_W-1:0] quot_q, acc_q;
  logic [REM_W-1:0]  remd_q, accr_q;
  logic [UP_W-1:0]   k_q;

  logic              in_xfer, out_free, keep, seg_end, tail_next;
  logic              div_start, seg_step, push, flush_go;
  logic              div_done;
  div_res_t          div_res;
  logic [DIFF_W-1:0] diff, diff_abs;
  logic [UP_W-1:0]   accr_sum, accr_sub;
  logic              carry;
  logic [DIFF_W:0]   p_wide, acc_signed;
  logic [DOWN_W:0]   phase_inc;

  // effective factors
  always_comb begin
    priority if (up_q == '0) begin
      up_eff = UP_W'(1);
    end else if (up_q > UP_W'(MAX_UP_FACTOR)) begin
      up_eff = UP_W'(MAX_UP_FACTOR);
    end else begin
      up_eff = up_q;
    end
    down_eff = (down_q == '0) ? DOWN_W'(1) : down_q;
  end

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_v_q || m_axis_tready;
  assign keep      = (phase_q == '0);
  assign seg_end   = (k_q == up_eff - 1'b1);
  assign tail_next = !tail_q && last_q;

  assign diff     = {s_axis_tdata[SAMPLE_BITS-1], s_axis_tdata}
                  - {prev_q[SAMPLE_BITS-1], prev_q};
  assign diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

  rlr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_abs),
    .divisor_i  (up_eff),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // incremental quotient and remainder of |diff| * k / up
  assign accr_sum   = {1'b0, accr_q} + {1'b0, remd_q};
  assign carry      = (accr_sum >= up_eff);
  assign accr_sub   = accr_sum - up_eff;
  assign acc_signed = neg_q ? (~{1'b0, acc_q} + 1'b1) : {1'b0, acc_q};
  assign p_wide     = {{2{f0_q[SAMPLE_BITS-1]}}, f0_q} + acc_signed;
  assign phase_inc  = {1'b0, phase_q} + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (have_q) begin
            state_d = ST_DIV;
          end else if (s_axis_tlast) begin
            state_d = ST_SEG;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        if (seg_step && seg_end && !tail_next) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    seg_step      = 1'b0;
    push          = 1'b0;
    flush_go      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = in_xfer && have_q;
      end
      ST_DIV: begin
      end
      ST_SEG: begin
        seg_step = !keep || !pend_v_q || out_free;
        push     = seg_step && keep && pend_v_q;
      end
      ST_FLUSH: begin
        flush_go = !pend_v_q || out_free;
        push     = pend_v_q && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      up_q     <= UP_W'(1);
      down_q   <= DOWN_W'(1);
      prev_q   <= '0;
      have_q   <= 1'b0;
      phase_q  <= '0;
      last_q   <= 1'b0;
      tail_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_UP_FACTOR:   up_q   <= cfg_data_i[UP_W-1:0];
          CFG_DOWN_FACTOR: down_q <= cfg_data_i[DOWN_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        last_q <= s_axis_tlast;
        tail_q <= !have_q;
        if (!have_q && !s_axis_tlast) begin
          prev_q <= s_axis_tdata;
          have_q <= 1'b1;
        end
      end
      if (seg_step) begin
        phase_q <= (phase_inc >= {1'b0, down_eff}) ? '0 : phase_inc[DOWN_W-1:0];
        if (keep) begin
          pend_v_q <= 1'b1;
        end
        if (seg_end && tail_next) begin
          tail_q <= 1'b1;
        end
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (flush_go) begin
        pend_v_q <= 1'b0;
        if (last_q) begin
          prev_q  <= '0;
          have_q  <= 1'b0;
          phase_q <= '0;
        end else begin
          prev_q <= cur_q;
          have_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_q  <= s_axis_tdata;
      f0_q   <= have_q ? prev_q : s_axis_tdata;
      neg_q  <= diff[DIFF_W-1];
      quot_q <= '0;
      remd_q <= '0;
      acc_q  <= '0;
      accr_q <= '0;
      k_q    <= '0;
    end
    if (div_done && state_q == ST_DIV) begin
      quot_q <= div_res.quot;
      remd_q <= div_res.rem;
      acc_q  <= '0;
      accr_q <= '0;
      k_q    <= '0;
    end
    if (seg_step) begin
      if (keep) begin
        pend_q <= p_wide[SAMPLE_BITS-1:0];
      end
      if (seg_end && tail_next) begin
        // flat tail segment at the final sample
        f0_q   <= cur_q;
        quot_q <= '0;
        remd_q <= '0;
        acc_q  <= '0;
        accr_q <= '0;
        k_q    <= '0;
      end else begin
        acc_q  <= acc_q + quot_q + DIFF_W'(carry);
        accr_q <= carry ? accr_sub[REM_W-1:0] : accr_sum[REM_W-1:0];
        k_q    <= k_q + 1'b1;
      end
    end
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= (state_q == ST_FLUSH);
      out_user_q <= (state_q == ST_FLUSH) && last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational linear resampler.
// ----------------------------------------------------------------------------
// Streams of signed samples go in on the slave side, and a software copy of
// the interpolate-and-decimate behavior predicts every point. Each output
// transfer is checked against the oldest predicted point: sample value, end of
// input run and end of stream. A directed opening covers the sample extremes,
// a single-sample stream, the factor limits, out-of-range factors, a
// decimation phase left past a newly written down factor, and stream ends
// whose tail points are all dropped. Random streams follow under several
// factor settings, with random gaps on both sides except near the end.
// ----------------------------------------------------------------------------
module tb_top;
  import rlr_pkg::*;

  localparam int      DRAIN_CYCLES = 128;
  localparam int      STALL_LIMIT  = 3000;
  localparam int      RUN_PHASES   = 10;
  localparam int      PHASE_ITEMS  = 50;
  localparam sample_t SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t value;
    logic    run_last;
    logic    stream_done;
  } point_t;

  class point_checker;
    logic [UP_W-1:0]   up_reg     = 1;
    logic [DOWN_W-1:0] down_reg   = 1;
    sample_t           held       = '0;
    bit                held_valid = 1'b0;
    int                phase      = 0;
    point_t            pending_points[$];
    int                errors     = 0;

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_UP_FACTOR) begin
        up_reg = value[UP_W-1:0];
      end else begin
        down_reg = value[DOWN_W-1:0];
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction

    // one segment from f0 to f1, kept points only
    function void interpolate_span(sample_t f0, sample_t f1);
      longint up_eff;
      longint dn;
      longint p;
      longint k;
      bit     keep;
      point_t pt;
      up_eff = (up_reg == 0) ? 1 : ((up_reg > MAX_UP_FACTOR) ? MAX_UP_FACTOR : up_reg);
      dn = (down_reg == 0) ? 1 : down_reg;
      for (k = 0; k < up_eff; k++) begin
        keep = (phase == 0);
        if (phase + 1 >= dn) begin
          phase = 0;
        end else begin
          phase++;
        end
        if (keep) begin
          p = longint'(f0) + ((longint'(f1) - longint'(f0)) * k) / up_eff;
          pt.value       = p[SAMPLE_BITS-1:0];
          pt.run_last    = 1'b0;
          pt.stream_done = 1'b0;
          pending_points.push_back(pt);
        end
      end
    endfunction

    function void note_sample(sample_t s, logic eos);
      int     first;
      point_t tail_pt;
      first = pending_points.size();
      if (held_valid) begin
        interpolate_span(held, s);
      end
      held       = s;
      held_valid = 1'b1;
      if (eos) begin
        interpolate_span(s, s);
        held       = '0;
        held_valid = 1'b0;
        phase      = 0;
      end
      if (pending_points.size() > first) begin
        tail_pt             = pending_points.pop_back();
        tail_pt.run_last    = 1'b1;
        tail_pt.stream_done = eos;
        pending_points.push_back(tail_pt);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) begin
        $display("%0t mismatch: %s", $time, msg);
      end
    endtask

    task check_point(logic [SAMPLE_BITS-1:0] data, logic last, logic done);
      point_t want;
      if (pending_points.size() == 0) begin
        report($sformatf("output %h with no point pending", data));
        return;
      end
      want = pending_points.pop_front();
      if (data !== want.value) begin
        report($sformatf("sample %h, expected %h", data, want.value));
      end
      if (last !== want.run_last) begin
        report($sformatf("run_last %b, expected %b", last, want.run_last));
      end
      if (done !== want.stream_done) begin
        report($sformatf("stream_done %b, expected %b", done, want.stream_done));
      end
    endtask
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_idx_i     = CFG_UP_FACTOR;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  point_checker sb = new;
  bit           gaps_on     = 1'b1;
  sample_t      last_sent   = '0;
  int           idle_cycles = 0;

  rational_linear_resampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side back-pressure
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_point(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_sample(input sample_t value, input logic eos);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(value, eos);
    last_sent = value;
  endtask

  // all points out, then room for a run that yields none
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_factors(input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] down);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_UP_FACTOR;
    cfg_data_i <= up;
    @(posedge clk_i);
    sb.write_reg(CFG_UP_FACTOR, up);
    cfg_idx_i  <= CFG_DOWN_FACTOR;
    cfg_data_i <= down;
    @(posedge clk_i);
    sb.write_reg(CFG_DOWN_FACTOR, down);
    cfg_we_i <= 1'b0;
  endtask

  function automatic sample_t pick_sample(sample_t near);
    sample_t s;
    case ($urandom_range(0, 9))
      0:       s = SAMPLE_MAX;
      1:       s = SAMPLE_MIN;
      2, 3:    s = sample_t'(near + $urandom_range(0, 2000) - 1000);
      4:       s = sample_t'($urandom_range(0, 511) - 256);
      default: s = sample_t'($urandom());
    endcase
    return s;
  endfunction

  function automatic logic [CFG_W-1:0] pick_up();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63));
      1, 2:    return CFG_W'($urandom_range(1, 3));
      default: return CFG_W'($urandom_range(1, MAX_UP_FACTOR));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_down();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(($urandom_range(0, 1) == 0) ? 0 : 255);
      1:       return CFG_W'($urandom_range(17, 255));
      2, 3:    return CFG_W'($urandom_range(5, 16));
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int stream_left;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset factors: single-sample stream, then full-swing steps
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    wait_drained();

    // largest up factor, every point kept
    write_factors(CFG_W'(MAX_UP_FACTOR), 1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    wait_drained();

    // zero factors act as one
    write_factors(0, 0);
    send_sample(5, 1'b0);
    send_sample(-7, 1'b1);
    wait_drained();

    // saturated up factor, widest decimation, stream left open
    write_factors(63, 255);
    send_sample(100, 1'b0);
    send_sample(-100, 1'b0);
    send_sample(12345, 1'b0);
    wait_drained();

    // phase now past the new down factor
    write_factors(63, 3);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    wait_drained();

    // stream end whose tail point is dropped
    write_factors(1, 2);
    send_sample(10, 1'b0);
    send_sample(20, 1'b1);
    wait_drained();

    // stream end that yields nothing at all
    write_factors(1, 3);
    send_sample(10, 1'b0);
    send_sample(20, 1'b0);
    send_sample(30, 1'b1);
    wait_drained();

    stream_left = $urandom_range(1, 24);
    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      gaps_on = (ph < RUN_PHASES - 2) && ($urandom_range(0, 3) != 0);
      write_factors(pick_up(), pick_down());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        stream_left--;
        send_sample(pick_sample(last_sent), stream_left == 0);
        if (stream_left == 0) begin
          stream_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
        end
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
